// ----- rtl/srle_pkg.sv -----
// Package for the S-record line encoder: request and result structs,
// the character job passed from the builder to the serializer, hex helper.
// No dependencies.
package srle_pkg;

    localparam int MAX_CHARS = 14;
    localparam int CNT_W     = 4;

    localparam logic       MODE_HDR  = 1'b0;
    localparam logic       MODE_DATA = 1'b1;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [3:0] TYPE_ZERO = 4'd0;
    localparam logic [3:0] TYPE_S3   = 4'd3;
    localparam logic [7:0] COUNT_ADJ = 8'd5;
    localparam logic [CNT_W-1:0] N_HDR      = 4'd12;
    localparam logic [CNT_W-1:0] N_HDR_CKS  = 4'd14;
    localparam logic [CNT_W-1:0] N_DATA     = 4'd2;
    localparam logic [CNT_W-1:0] N_DATA_CKS = 4'd4;

    typedef struct packed {
        logic        mode;
        logic [3:0]  record_type;
        logic [31:0] address;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       record_end;
    } t_out;

    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          n;
        logic                      cks;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'h0, nib};
        end else begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

endpackage

// ----- rtl/srle_build.sv -----
// Character job builder: holds the running sum and bytes left, and turns
// one accepted request into its list of ASCII characters.
// Depends on srle_pkg.
module srle_build
    import srle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  t_in  i_item,
    output logic o_load,
    output t_job o_job
);

    logic [7:0] r_sum, n_sum;
    logic [7:0] r_left, n_left;
    logic [7:0] field;
    logic [7:0] cks;
    logic [3:0] rtype;

    always_comb begin
        n_sum  = r_sum;
        n_left = r_left;
        o_load = 1'b0;
        o_job  = '0;
        field  = i_item.byte_count + COUNT_ADJ;
        rtype  = (i_item.record_type == TYPE_ZERO) ? TYPE_S3 : i_item.record_type;
        cks    = 8'h00;
        if (i_item.mode == MODE_HDR) begin
            n_sum = field + i_item.address[7:0] + i_item.address[15:8]
                  + i_item.address[23:16] + i_item.address[31:24];
            n_left = i_item.byte_count;
            cks = ~n_sum;
            o_load = 1'b1;
            o_job.chars[0] = CHAR_S;
            o_job.chars[1] = hex_char(rtype);
            o_job.chars[2] = hex_char(field[7:4]);
            o_job.chars[3] = hex_char(field[3:0]);
            for (int i = 0; i < 8; i++) begin
                o_job.chars[4+i] = hex_char(i_item.address[28-4*i +: 4]);
            end
            o_job.chars[12] = hex_char(cks[7:4]);
            o_job.chars[13] = hex_char(cks[3:0]);
            o_job.cks = (n_left == 8'd0);
            o_job.n   = o_job.cks ? N_HDR_CKS : N_HDR;
        end else if (r_left != 8'd0) begin
            n_sum  = r_sum + i_item.data_byte;
            n_left = r_left - 8'd1;
            cks = ~n_sum;
            o_load = 1'b1;
            o_job.chars[0] = hex_char(i_item.data_byte[7:4]);
            o_job.chars[1] = hex_char(i_item.data_byte[3:0]);
            o_job.chars[2] = hex_char(cks[7:4]);
            o_job.chars[3] = hex_char(cks[3:0]);
            o_job.cks = (n_left == 8'd0);
            o_job.n   = o_job.cks ? N_DATA_CKS : N_DATA;
        end
        if (o_job.cks) begin
            n_sum = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 8'h00;
            r_left <= 8'h00;
        end else if (i_acc) begin
            r_sum  <= n_sum;
            r_left <= n_left;
        end
    end

endmodule

// ----- rtl/srle_ser.sv -----
// Character serializer: holds one job, shifts out one character per cycle into
// the output register while the output is not stalled. Depends on srle_pkg.
module srle_ser
    import srle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_job i_job,
    output logic o_free,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_item
);

    logic [MAX_CHARS-1:0][7:0] r_chars;
    logic [CNT_W-1:0]          r_left;
    logic                      r_cks;
    logic                      r_ov;
    t_out                      r_out;
    logic                      move;

    assign move    = (r_left != '0) && (!r_ov || i_ready);
    assign o_free  = (r_left == '0) || ((r_left == CNT_W'(1)) && move);
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_cks  <= 1'b0;
        end else if (i_load) begin
            r_left <= i_job.n;
            r_cks  <= i_job.cks;
        end else if (move) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_job.chars;
        end else if (move) begin
            r_chars <= r_chars >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (move) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.out_char   <= r_chars[0];
            r_out.record_end <= r_cks && (r_left == CNT_W'(1));
        end
    end

endmodule

// ----- rtl/srecord_line_encoder.sv -----
// S-record line encoder top: one ASCII character per result.
// Characters enter the serializer on acceptance, then the output register;
// one character per cycle unless the output stalls, set by the single output
// port. A data request gives 2 chars (4 with checksum), a header 12 (14).
// Reset: synchronous active low; clears sum, count and all valid state.
module srecord_line_encoder
    import srle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    logic acc;
    logic load;
    t_job job;

    assign acc = i_in_valid && o_in_ready;

    srle_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_item  (i_in_item),
        .o_load  (load),
        .o_job   (job)
    );

    srle_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (acc && load),
        .i_job   (job),
        .o_free  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ----- rtl/srle_chk.sv -----
// Port-level checker for the S-record line encoder, bound to the top level.
// Depends on srle_pkg.
module srle_chk
    import srle_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_item,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_item
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("request changed while stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_end_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.record_end |->
            (o_out_item.out_char >= 8'h30 && o_out_item.out_char <= 8'h39) ||
            (o_out_item.out_char >= 8'h41 && o_out_item.out_char <= 8'h46))
        else $error("record end on non-hex character");

    a_s_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_char == CHAR_S |-> !o_out_item.record_end)
        else $error("record end on start character");

endmodule

bind srecord_line_encoder srle_chk u_chk (.*);
